// ===== design/aes128_pkg.sv =====
package aes128_pkg;

   localparam int RoundCount = 10;

   typedef logic [7:0] byte_type;
   typedef logic [127:0] block_type;

   // one word travelling down the round chain
   typedef struct packed {
      logic      valid;
      block_type state;
      block_type key;
      byte_type  rcon;
   } stage_type;

   // forward substitution table, entry 0 in the top byte
   localparam logic [2047:0] SboxTable = {
      128'h637c777bf26b6fc53001672bfed7ab76,
      128'hca82c97dfa5947f0add4a2af9ca472c0,
      128'hb7fd9326363ff7cc34a5e5f171d83115,
      128'h04c723c31896059a071280e2eb27b275,
      128'h09832c1a1b6e5aa0523bd6b329e32f84,
      128'h53d100ed20fcb15b6acbbe394a4c58cf,
      128'hd0efaafb434d338545f9027f503c9fa8,
      128'h51a3408f929d38f5bcb6da2110fff3d2,
      128'hcd0c13ec5f974417c4a77e3d645d1973,
      128'h60814fdc222a908846eeb814de5e0bdb,
      128'he0323a0a4906245cc2d3ac629195e479,
      128'he7c8376d8dd54ea96c56f4ea657aae08,
      128'hba78252e1ca6b4c6e8dd741f4bbd8b8a,
      128'h703eb5664803f60e613557b986c11d9e,
      128'he1f8981169d98e949b1e87e9ce5528df,
      128'h8ca1890dbfe6426841992d0fb054bb16
   };

   function automatic byte_type gf_double(input byte_type a);
      gf_double = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
   endfunction

   // substitution as constant logic: entry a sits at bits 8*(255-a) upward
   function automatic byte_type sbox(input byte_type a);
      return SboxTable[{~a, 3'b000} +: 8];
   endfunction

   // byte i of a block sits at bits 127-8i downto 120-8i
   function automatic byte_type get_byte(input block_type b, input int i);
      return b[127 - 8 * i -: 8];
   endfunction

endpackage

// ===== design/aes128_round_cell.sv =====
module aes128_round_cell (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  advance,
   input  logic                  is_final,
   input  aes128_pkg::stage_type prev,
   output aes128_pkg::stage_type next
);
   import aes128_pkg::*;

   stage_type next_ff, next_in;
   byte_type  sh [16];
   byte_type  mx [16];
   byte_type  k  [16];
   byte_type  nk [16];

   always_comb begin
      byte_type a0, a1, a2, a3, all;
      next_in = prev;
      // sub bytes and shift rows
      for (int c = 0; c < 4; c++)
         for (int r = 0; r < 4; r++)
            sh[4 * c + r] = sbox(get_byte(prev.state, 4 * ((c + r) % 4) + r));
      // mix columns
      for (int c = 0; c < 4; c++) begin
         a0 = sh[4 * c];
         a1 = sh[4 * c + 1];
         a2 = sh[4 * c + 2];
         a3 = sh[4 * c + 3];
         all = a0 ^ a1 ^ a2 ^ a3;
         mx[4 * c]     = is_final ? a0 : a0 ^ all ^ gf_double(a0 ^ a1);
         mx[4 * c + 1] = is_final ? a1 : a1 ^ all ^ gf_double(a1 ^ a2);
         mx[4 * c + 2] = is_final ? a2 : a2 ^ all ^ gf_double(a2 ^ a3);
         mx[4 * c + 3] = is_final ? a3 : a3 ^ all ^ gf_double(a3 ^ a0);
      end
      // expand the next round key
      for (int i = 0; i < 16; i++) k[i] = get_byte(prev.key, i);
      nk[0] = k[0] ^ prev.rcon ^ sbox(k[13]);
      nk[1] = k[1] ^ sbox(k[14]);
      nk[2] = k[2] ^ sbox(k[15]);
      nk[3] = k[3] ^ sbox(k[12]);
      for (int i = 4; i < 16; i++) nk[i] = k[i] ^ nk[i - 4];
      for (int i = 0; i < 16; i++) begin
         next_in.key[127 - 8 * i -: 8]   = nk[i];
         next_in.state[127 - 8 * i -: 8] = mx[i] ^ nk[i];
      end
      next_in.rcon = gf_double(prev.rcon);
   end

   // advance the word when the chain moves
   always_ff @(posedge clock) begin
      if (reset) begin
         next_ff.valid <= 1'b0;
      end else if (advance) begin
         next_ff <= next_in;
      end
   end

   assign next = next_ff;
endmodule

// ===== design/aes128_block_encrypt_core.sv =====
// AES-128 block encryptor, one fully unrolled round per pipeline cell.
// Request channel: req_valid with plaintext and key halves, accepted at a
// clock edge where req_valid is high and req_stall is low. Byte 0 sits in
// the top bits of each high half.
// Response channel: rsp_valid with ciphertext halves, taken when rsp_stall
// is low.
// The word passes the input register for the initial key add, loaded at the
// accepting edge, then ten round cells, before rsp_valid rises.
// Throughput: one block per cycle while rsp_stall does not hold the chain; the
// rate is set by the ten-cell chain, which moves one word per cell each cycle.
// Stall: the whole chain holds while the output word waits and rsp_stall is
// high; req_stall then rises, so no word is lost or repeated. The chain
// moves as one unit, so empty cells do not fill while the output waits.
// Reset: synchronous, clears all valid bits; the pipeline comes up empty.
module aes128_block_encrypt_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [63:0] req_plaintext_high,
   input  logic [63:0] req_plaintext_low,
   input  logic [63:0] req_key_high,
   input  logic [63:0] req_key_low,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [63:0] rsp_ciphertext_high,
   output logic [63:0] rsp_ciphertext_low
);
   import aes128_pkg::*;

   stage_type chain [RoundCount + 1];
   stage_type head_ff;
   logic      advance;

   // move the chain unless a finished word is held
   assign advance   = !(chain[RoundCount].valid && rsp_stall);
   assign req_stall = !advance;

   // initial key add
   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff.valid <= 1'b0;
      end else if (advance) begin
         head_ff.valid <= req_valid;
         head_ff.state <= {req_plaintext_high, req_plaintext_low}
                        ^ {req_key_high, req_key_low};
         head_ff.key   <= {req_key_high, req_key_low};
         head_ff.rcon  <= 8'h01;
      end
   end

   assign chain[0] = head_ff;

   for (genvar g = 0; g < RoundCount; g++) begin : g_round
      aes128_round_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .advance  (advance),
         .is_final (g == RoundCount - 1),
         .prev     (chain[g]),
         .next     (chain[g + 1])
      );
   end

   assign rsp_valid           = chain[RoundCount].valid;
   assign rsp_ciphertext_high = chain[RoundCount].state[127:64];
   assign rsp_ciphertext_low  = chain[RoundCount].state[63:0];
endmodule
